### sv/ufse_pkg.sv
// ----------------------------------------------------------------------------
// ufse_pkg: shared types for the union-find splice engine
// Node width, table depth and the command/status bundles between controller
// and datapath.
// ----------------------------------------------------------------------------
package ufse_pkg;

    localparam int NODE_COUNT = 1024;
    localparam int NODE_W     = $clog2(NODE_COUNT);

    typedef logic [NODE_W-1:0] t_node;

    // Datapath operations issued by the controller
    typedef enum logic [2:0] {
        DP_NOP,
        DP_CLEAR,
        DP_LOAD,
        DP_SPLICE_U,
        DP_SPLICE_W,
        DP_CLIMB,
        DP_COMPRESS
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   kind;
        t_node  node_a;
        t_node  node_b;
    } t_dp_cmd;

    typedef struct packed {
        logic  clear_last;   // clearing pass writes its final entry
        logic  par_eq;       // parent(u) == parent(w)
        logic  par_gt;       // parent(u) >  parent(w)
        logic  u_root;       // u is its own parent
        logic  w_root;       // w is its own parent
        logic  at_top;       // u == w
        logic  next_at_top;  // parent(u) == w
        t_node top;          // current w walker, the root after a find
    } t_dp_status;

endpackage

### sv/ufse_datapath.sv
// ----------------------------------------------------------------------------
// ufse_datapath: parent table and walk registers
// Holds the 1024-entry parent memory (one write, two registered reads) and
// the two walker registers u and w. Executes one command per cycle.
// ----------------------------------------------------------------------------
module ufse_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ufse_pkg::t_dp_cmd     i_cmd,
    output ufse_pkg::t_dp_status  o_status
);
    import ufse_pkg::*;

    t_node mem [NODE_COUNT];

    t_node r_u;
    t_node r_w;
    t_node r_rd0;
    t_node r_rd1;
    t_node r_clr;

    logic  wr_en;
    t_node wr_addr;
    t_node wr_data;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_u;
        wr_data = r_w;
        case (i_cmd.op)
            DP_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = r_clr;
            end
            DP_SPLICE_U: begin
                wr_en   = 1'b1;
                wr_addr = r_u;
                wr_data = r_rd1;
            end
            DP_SPLICE_W: begin
                wr_en   = 1'b1;
                wr_addr = r_w;
                wr_data = r_rd0;
            end
            DP_COMPRESS: begin
                wr_en   = 1'b1;
                wr_addr = r_u;
                wr_data = r_w;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        // read both walkers every cycle; a write lands before the next read
        r_rd0 <= mem[r_u];
        r_rd1 <= mem[r_w];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.op == DP_CLEAR) begin
            r_clr <= r_clr + t_node'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            DP_LOAD: begin
                r_u <= i_cmd.node_a;
                r_w <= i_cmd.kind ? i_cmd.node_a : i_cmd.node_b;
            end
            DP_SPLICE_U: r_u <= r_rd0;
            DP_SPLICE_W: r_w <= r_rd1;
            DP_CLIMB:    r_w <= r_rd1;
            DP_COMPRESS: r_u <= r_rd0;
            default: ;
        endcase
    end

    assign o_status.clear_last  = (r_clr == t_node'(NODE_COUNT - 1));
    assign o_status.par_eq      = (r_rd0 == r_rd1);
    assign o_status.par_gt      = (r_rd0 > r_rd1);
    assign o_status.u_root      = (r_rd0 == r_u);
    assign o_status.w_root      = (r_rd1 == r_w);
    assign o_status.at_top      = (r_u == r_w);
    assign o_status.next_at_top = (r_rd0 == r_w);
    assign o_status.top         = r_w;

endmodule

### sv/ufse_ctrl.sv
// ----------------------------------------------------------------------------
// ufse_ctrl: sequencer for the union-find splice engine
// Runs the clearing pass, steps insert splicing and find/compress walks one
// memory read-modify-write at a time, and owns the result register.
// ----------------------------------------------------------------------------
module ufse_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_in_kind,
    input  ufse_pkg::t_node       i_in_node_a,
    input  ufse_pkg::t_node       i_in_node_b,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_out_kind,
    output logic                  o_out_linked,
    output ufse_pkg::t_node       o_out_root,
    output ufse_pkg::t_dp_cmd     o_cmd,
    input  ufse_pkg::t_dp_status  i_status
);
    import ufse_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INS_RD,
        S_INS_EV,
        S_F1_RD,
        S_F1_EV,
        S_F2_RD,
        S_F2_EV,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_kind, n_kind;
    logic   r_linked, n_linked;
    logic   r_out_valid, n_out_valid;
    logic   r_out_kind, n_out_kind;
    logic   r_out_linked, n_out_linked;
    t_node  r_out_root, n_out_root;

    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_linked     = r_linked;
        n_out_valid  = r_out_valid;
        n_out_kind   = r_out_kind;
        n_out_linked = r_out_linked;
        n_out_root   = r_out_root;
        o_cmd.op     = DP_NOP;
        o_cmd.kind   = i_in_kind;
        o_cmd.node_a = i_in_node_a;
        o_cmd.node_b = i_in_node_b;

        // drop the result once the sink takes it
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                o_cmd.op = DP_CLEAR;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.op = DP_LOAD;
                    n_kind   = i_in_kind;
                    n_linked = 1'b0;
                    n_state  = i_in_kind ? S_F1_RD : S_INS_RD;
                end
            end
            S_INS_RD: n_state = S_INS_EV;
            S_INS_EV: begin
                if (i_status.par_eq) begin
                    n_state = S_FIN;
                end else if (i_status.par_gt) begin
                    o_cmd.op = DP_SPLICE_U;
                    n_linked = i_status.u_root;
                    n_state  = i_status.u_root ? S_FIN : S_INS_RD;
                end else begin
                    o_cmd.op = DP_SPLICE_W;
                    n_linked = i_status.w_root;
                    n_state  = i_status.w_root ? S_FIN : S_INS_RD;
                end
            end
            S_F1_RD: n_state = S_F1_EV;
            S_F1_EV: begin
                if (!i_status.w_root) begin
                    o_cmd.op = DP_CLIMB;
                    n_state  = S_F1_RD;
                end else begin
                    n_state = i_status.at_top ? S_FIN : S_F2_RD;
                end
            end
            S_F2_RD: n_state = S_F2_EV;
            S_F2_EV: begin
                o_cmd.op = DP_COMPRESS;
                n_state  = i_status.next_at_top ? S_FIN : S_F2_RD;
            end
            S_FIN: begin
                // hold until the result slot is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_kind;
                    n_out_linked = r_kind ? 1'b0 : r_linked;
                    n_out_root   = r_kind ? i_status.top : '0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_kind      <= 1'b0;
            r_linked    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_kind      <= n_kind;
            r_linked    <= n_linked;
        end
        r_out_kind   <= n_out_kind;
        r_out_linked <= n_out_linked;
        r_out_root   <= n_out_root;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_kind   = r_out_kind;
    assign o_out_linked = r_out_linked;
    assign o_out_root   = r_out_root;

endmodule

### sv/union_find_splice_engine.sv
// Insert: splices up from both nodes until their parents match or a root is linked;
//   find: climbs to the root, then compresses each node on the path onto it.
// Throughput: one item at a time, each step is one read-modify-write on the
//   single-write-port parent memory.
// Reset: i_rst_n is synchronous; afterwards a clearing pass sets every parent
//   to its own index while s_axis_tready stays low.
// ----------------------------------------------------------------------------
// union_find_splice_engine: Rem union with splicing and path-compressing find
// Stream in edges or find queries, stream out linked flags and roots.
// ----------------------------------------------------------------------------
module union_find_splice_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [9:0] node_a, [19:10] node_b, [23:20] zero
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] linked, [10:1] root, [15:11] zero
    output logic        m_axis_tuser    // [0] done_kind
);
    import ufse_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       out_linked;
    t_node      out_root;

    ufse_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_kind    (s_axis_tuser),
        .i_in_node_a  (s_axis_tdata[NODE_W-1:0]),
        .i_in_node_b  (s_axis_tdata[2*NODE_W-1:NODE_W]),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_kind   (m_axis_tuser),
        .o_out_linked (out_linked),
        .o_out_root   (out_root),
        .o_cmd        (dp_cmd),
        .i_status     (dp_status)
    );

    ufse_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .o_status (dp_status)
    );

    assign m_axis_tdata = {5'b0, out_root, out_linked};

endmodule

### sv/ufse_port_checker.sv
// ----------------------------------------------------------------------------
// ufse_port_checker: port-level checks for the union-find splice engine
// Watches the stream ports of the top level; bound in below.
// ----------------------------------------------------------------------------
module ufse_port_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // clearing pass follows reset, so no beat is taken right after it
    a_no_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready right after reset");

    // one item in flight: ready drops after every accepted beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second beat accepted while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_insert_no_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:1] == 15'd0)
        else $error("insert result carries a root");

    a_find_no_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[0] && m_axis_tdata[15:11] == 5'd0)
        else $error("find result carries a link flag");

endmodule

bind union_find_splice_engine ufse_port_checker u_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
